// ===== hdl/bump_arena_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// bump arena allocator assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef BUMP_ARENA_ALLOCATOR_CORE_ASSERT_SVH
`define BUMP_ARENA_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define BAA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BAA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/baa_pkg.sv =====
// ----------------------------------------------------------------------------
// baa_pkg
// shared types, codes and reset constants of the bump arena allocator
// ----------------------------------------------------------------------------
package baa_pkg;

  localparam int unsigned CountBits   = 48;
  localparam int unsigned LoBits      = CountBits / 2;
  localparam int unsigned HiBits      = CountBits - LoBits;
  localparam int unsigned ThrBits     = 17;
  localparam int unsigned QBits       = 16;
  localparam int unsigned MetaBits    = 7;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [31:0]         MinBlockRst = 32'd65536;
  localparam logic [31:0]         MaxBlockRst = 32'd16777216;
  localparam logic [ThrBits-1:0]  GcThrRst    = 17'd32768;
  localparam logic [MetaBits-1:0] MetaRst     = 7'd8;
  localparam logic [32:0]         TwiceMinRst = {MinBlockRst, 1'b0};
  localparam logic [31:0]         NextBlockRst =
      (TwiceMinRst > {1'b0, MaxBlockRst}) ? MaxBlockRst : TwiceMinRst[31:0];

  localparam logic [31:0] RoundCap  = 32'hFFFF_FFF8;
  localparam logic [31:0] FieldBase = 32'd16;

  typedef enum logic [1:0] {
    OpInit  = 2'd0,
    OpAlloc = 2'd1,
    OpDeath = 2'd2
  } baa_op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgMinBlock    = 2'd0,
    CfgMaxBlock    = 2'd1,
    CfgGcThreshold = 2'd2,
    CfgMeta        = 2'd3
  } baa_cfg_idx_e;

  typedef logic [CountBits-1:0] cnt_t;

  typedef struct packed {
    logic [31:0]         min_block_bytes;
    logic [31:0]         max_block_bytes;
    logic [ThrBits-1:0]  gc_threshold_q16;
    logic [MetaBits-1:0] meta_bytes;
  } baa_cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] request_bytes;
  } baa_in_t;

  typedef struct packed {
    logic [31:0] payload_offset;
    logic        new_block;
    logic [31:0] block_bytes;
    logic [31:0] rounded_bytes;
    logic [28:0] field_count;
    logic        gc_due;
    cnt_t        used_total;
    cnt_t        live_total;
    cnt_t        reserved_total;
  } baa_out_t;

endpackage

// ===== hdl/baa_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// baa_cfg_regs
// configuration register file written through the config channel
// ----------------------------------------------------------------------------
module baa_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [baa_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [baa_pkg::CfgDataBits-1:0]    cfg_data_i,
  output baa_pkg::baa_cfg_t                  cfg_o
);

  baa_pkg::baa_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_block_bytes  <= baa_pkg::MinBlockRst;
      cfg_q.max_block_bytes  <= baa_pkg::MaxBlockRst;
      cfg_q.gc_threshold_q16 <= baa_pkg::GcThrRst;
      cfg_q.meta_bytes       <= baa_pkg::MetaRst;
    end else if (cfg_valid_i) begin
      case (baa_pkg::baa_cfg_idx_e'(cfg_index_i))
        baa_pkg::CfgMinBlock: begin
          cfg_q.min_block_bytes <= cfg_data_i[31:0];
        end
        baa_pkg::CfgMaxBlock: begin
          cfg_q.max_block_bytes <= cfg_data_i[31:0];
        end
        baa_pkg::CfgGcThreshold: begin
          cfg_q.gc_threshold_q16 <= cfg_data_i[baa_pkg::ThrBits-1:0];
        end
        baa_pkg::CfgMeta: begin
          cfg_q.meta_bytes <= cfg_data_i[baa_pkg::MetaBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/baa_alloc_unit.sv =====
// ----------------------------------------------------------------------------
// baa_alloc_unit
// input register, arena state and per-operation update with result register
// ----------------------------------------------------------------------------
module baa_alloc_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  baa_pkg::baa_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  baa_pkg::baa_in_t   in_data_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output baa_pkg::baa_out_t  res_data_o
);

  function automatic logic [31:0] next_size(logic [31:0] cur, logic [31:0] lim);
    logic [32:0] dbl;
    dbl = {cur, 1'b0};
    return (dbl > {1'b0, lim}) ? lim : dbl[31:0];
  endfunction

  function automatic baa_pkg::cnt_t sat_add(baa_pkg::cnt_t a, baa_pkg::cnt_t b);
    logic [baa_pkg::CountBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[baa_pkg::CountBits] ? '1 : s[baa_pkg::CountBits-1:0];
  endfunction

  logic              s1_valid_q;
  baa_pkg::baa_in_t  s1_q;
  logic              s2_valid_q;
  baa_pkg::baa_out_t s2_q;
  baa_pkg::baa_out_t res_d;

  logic [31:0]   cap_q, cap_d;
  logic [31:0]   fill_q, fill_d;
  logic [31:0]   next_q, next_d;
  baa_pkg::cnt_t used_q, used_d;
  baa_pkg::cnt_t live_q, live_d;
  baa_pkg::cnt_t rsv_q, rsv_d;

  logic          s1_ready, s2_ready, step;
  logic [33:0]   sum_ext, rnd_ext;
  logic [31:0]   rnd_all, fld_diff, new_cap, base_fill;
  logic [28:0]   fld_all;
  logic          need_new;
  baa_pkg::cnt_t rnd_cnt;

  assign s2_ready    = !s2_valid_q || res_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign step        = s1_valid_q && s2_ready;
  assign in_ready_o  = s1_ready;
  assign res_valid_o = s2_valid_q;
  assign res_data_o  = s2_q;

  always_comb begin
    sum_ext   = {2'b00, s1_q.request_bytes} + {27'd0, cfg_i.meta_bytes} + 34'd7;
    rnd_ext   = {sum_ext[33:3], 3'b000};
    rnd_all   = (rnd_ext > {2'b00, baa_pkg::RoundCap}) ? baa_pkg::RoundCap : rnd_ext[31:0];
    rnd_cnt   = baa_pkg::cnt_t'(rnd_all);
    fld_diff  = s1_q.request_bytes - baa_pkg::FieldBase;
    fld_all   = (s1_q.request_bytes >= baa_pkg::FieldBase) ? fld_diff[31:3] : '0;
    need_new  = ({1'b0, fill_q} + {1'b0, rnd_all}) > {1'b0, cap_q};
    new_cap   = (rnd_all > next_q) ? rnd_all : next_q;
    base_fill = need_new ? '0 : fill_q;

    cap_d  = cap_q;
    fill_d = fill_q;
    next_d = next_q;
    used_d = used_q;
    live_d = live_q;
    rsv_d  = rsv_q;
    res_d  = '0;

    case (s1_q.operation)
      baa_pkg::OpInit: begin
        cap_d  = cfg_i.min_block_bytes;
        fill_d = '0;
        next_d = next_size(cfg_i.min_block_bytes, cfg_i.max_block_bytes);
        used_d = '0;
        live_d = '0;
        rsv_d  = baa_pkg::cnt_t'(cfg_i.min_block_bytes);
      end
      baa_pkg::OpAlloc: begin
        res_d.rounded_bytes = rnd_all;
        res_d.field_count   = fld_all;
        if (need_new) begin
          cap_d           = new_cap;
          next_d          = next_size(next_q, cfg_i.max_block_bytes);
          rsv_d           = sat_add(rsv_q, baa_pkg::cnt_t'(new_cap));
          res_d.new_block = 1'b1;
        end
        res_d.payload_offset = base_fill + {25'd0, cfg_i.meta_bytes};
        fill_d = base_fill + rnd_all;
        used_d = sat_add(used_q, rnd_cnt);
        live_d = sat_add(live_q, rnd_cnt);
      end
      baa_pkg::OpDeath: begin
        res_d.rounded_bytes = rnd_all;
        res_d.field_count   = fld_all;
        live_d = (live_q >= rnd_cnt) ? live_q - rnd_cnt : '0;
      end
      default: begin
      end
    endcase

    res_d.block_bytes    = cap_d;
    res_d.used_total     = used_d;
    res_d.live_total     = live_d;
    res_d.reserved_total = rsv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      cap_q      <= baa_pkg::MinBlockRst;
      fill_q     <= '0;
      next_q     <= baa_pkg::NextBlockRst;
      used_q     <= '0;
      live_q     <= '0;
      rsv_q      <= baa_pkg::cnt_t'(baa_pkg::MinBlockRst);
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (step) begin
        cap_q  <= cap_d;
        fill_q <= fill_d;
        next_q <= next_d;
        used_q <= used_d;
        live_q <= live_d;
        rsv_q  <= rsv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= in_data_i;
    end
    if (step) begin
      s2_q <= res_d;
    end
  end

endmodule

// ===== hdl/baa_gc_unit.sv =====
// ----------------------------------------------------------------------------
// baa_gc_unit
// split threshold product and dead-fraction compare feeding the output register
// ----------------------------------------------------------------------------
module baa_gc_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [baa_pkg::ThrBits-1:0]    thr_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  baa_pkg::baa_out_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output baa_pkg::baa_out_t              out_data_o
);

  localparam int unsigned LoW  = baa_pkg::ThrBits + baa_pkg::LoBits;
  localparam int unsigned HiW  = baa_pkg::ThrBits + baa_pkg::HiBits;
  localparam int unsigned CmpW = baa_pkg::ThrBits + baa_pkg::CountBits;

  logic              s3_valid_q;
  baa_pkg::baa_out_t s3_q;
  baa_pkg::cnt_t     dead_q, dead_d;
  logic              used_nz_q;
  logic [LoW-1:0]    plo_q, plo_d;
  logic [HiW-1:0]    phi_q, phi_d;
  logic              out_valid_q;
  baa_pkg::baa_out_t out_q, out_d;

  logic              s3_ready, s4_ready;
  logic [CmpW-1:0]   lhs, rhs;

  assign s4_ready    = !out_valid_q || out_ready_i;
  assign s3_ready    = !s3_valid_q || s4_ready;
  assign in_ready_o  = s3_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    dead_d = (in_data_i.used_total > in_data_i.live_total) ?
             in_data_i.used_total - in_data_i.live_total : '0;
    plo_d  = {{baa_pkg::LoBits{1'b0}}, thr_i} *
             {{baa_pkg::ThrBits{1'b0}}, in_data_i.used_total[baa_pkg::LoBits-1:0]};
    phi_d  = {{baa_pkg::HiBits{1'b0}}, thr_i} *
             {{baa_pkg::ThrBits{1'b0}},
              in_data_i.used_total[baa_pkg::CountBits-1:baa_pkg::LoBits]};
  end

  always_comb begin
    lhs          = {{(baa_pkg::ThrBits - baa_pkg::QBits){1'b0}}, dead_q,
                    {baa_pkg::QBits{1'b0}}};
    rhs          = {phi_q, {baa_pkg::LoBits{1'b0}}} + {{baa_pkg::HiBits{1'b0}}, plo_q};
    out_d        = s3_q;
    out_d.gc_due = used_nz_q && (lhs >= rhs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= in_valid_i;
      end
      if (s4_ready) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s3_ready) begin
      s3_q      <= in_data_i;
      dead_q    <= dead_d;
      used_nz_q <= |in_data_i.used_total;
      plo_q     <= plo_d;
      phi_q     <= phi_d;
    end
    if (s3_valid_q && s4_ready) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== hdl/bump_arena_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bump_arena_allocator_core
// an input transfer passes the input, result, gc stage and output registers in order
// throughput: one operation per cycle through a four-register pipeline while out_ready_i does not stall it
// the threshold product is split into low and high halves registered in the stage ahead of the output register
// reset: config registers take their defaults and the arena is initialized
// ----------------------------------------------------------------------------
`include "bump_arena_allocator_core_assert.svh"

module bump_arena_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [baa_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [baa_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  baa_pkg::baa_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output baa_pkg::baa_out_t               out_data_o
);

  baa_pkg::baa_cfg_t cfg;
  logic              res_valid, res_ready;
  baa_pkg::baa_out_t res_data;

  baa_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  baa_alloc_unit u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  baa_gc_unit u_gc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (cfg.gc_threshold_q16),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `BAA_ASSERT_NOW(a_new_block_fits, out_valid_o && out_data_o.new_block,
    out_data_o.rounded_bytes <= out_data_o.block_bytes, "new block smaller than object")
  `BAA_ASSERT_NOW(a_live_le_used, out_valid_o,
    out_data_o.live_total <= out_data_o.used_total &&
    baa_pkg::cnt_t'(out_data_o.block_bytes) <= out_data_o.reserved_total,
    "counter ordering broken")
  `BAA_ASSERT_NOW(a_empty_pipe_ready, !out_valid_o, in_ready_o,
    "input stalled with empty output stage")
  `BAA_ASSERT_NEXT(a_meta_write, cfg_valid_i && cfg_index_i == baa_pkg::CfgMeta,
    cfg.meta_bytes == $past(cfg_data_i[baa_pkg::MetaBits-1:0]), "meta register not written")

endmodule
